FILE: rtl/core/tks_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tks_pkg;

    localparam int unsigned POS_W   = 20;
    localparam int unsigned SPEED_W = 24;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned WGT_W   = 9;

    typedef enum logic [IDX_W-1:0] {
        CFG_MOVE_GATE       = 3'd0,
        CFG_VELOCITY_SMOOTH = 3'd1,
        CFG_FLING_MAX       = 3'd2,
        CFG_INERTIA_DECAY   = 3'd3,
        CFG_COAST_FLOOR     = 3'd4
    } cfg_index_t;

    localparam logic [CFG_W-1:0] RST_MOVE_GATE       = 16'd80;
    localparam logic [WGT_W-1:0] RST_VELOCITY_SMOOTH = 9'd154;
    localparam logic [CFG_W-1:0] RST_FLING_MAX       = 16'd800;
    localparam logic [WGT_W-1:0] RST_INERTIA_DECAY   = 9'd230;
    localparam logic [CFG_W-1:0] RST_COAST_FLOOR     = 16'd5;
    localparam logic [WGT_W-1:0] WGT_ONE             = 9'd256;

    typedef struct packed {
        logic [CFG_W-1:0] move_gate;
        logic [WGT_W-1:0] smooth_w;
        logic [CFG_W-1:0] fling_max;
        logic [WGT_W-1:0] decay_w;
        logic [CFG_W-1:0] coast_floor;
    } cfg_t;

    typedef struct packed {
        logic             pointer_down;
        logic             pointer_over;
        logic [POS_W-1:0] pointer_y;
        logic [POS_W-1:0] scroll_now;
        logic [POS_W-1:0] scroll_limit;
        logic             other_widget_active;
    } frame_t;

    typedef struct packed {
        logic               touching;
        logic               drag_on;
        logic               other_was_active;
        logic [POS_W-1:0]   press_y;
        logic [POS_W-1:0]   scroll_at_press;
        logic [POS_W-1:0]   last_y;
        logic [SPEED_W-1:0] speed;
    } state_t;

    typedef struct packed {
        logic             scroll_write;
        logic [POS_W-1:0] scroll_next;
        logic             dragging;
        logic             swallow_press;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/tks_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module tks_cfg
    import tks_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [CFG_W-1:0] move_gate_reg;
    logic [WGT_W-1:0] velocity_smooth_reg;
    logic [CFG_W-1:0] fling_max_reg;
    logic [WGT_W-1:0] inertia_decay_reg;
    logic [CFG_W-1:0] coast_floor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_gate_reg       <= RST_MOVE_GATE;
            velocity_smooth_reg <= RST_VELOCITY_SMOOTH;
            fling_max_reg       <= RST_FLING_MAX;
            inertia_decay_reg   <= RST_INERTIA_DECAY;
            coast_floor_reg     <= RST_COAST_FLOOR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MOVE_GATE:       move_gate_reg       <= cfg_data;
                CFG_VELOCITY_SMOOTH: velocity_smooth_reg <= cfg_data[WGT_W-1:0];
                CFG_FLING_MAX:       fling_max_reg       <= cfg_data;
                CFG_INERTIA_DECAY:   inertia_decay_reg   <= cfg_data[WGT_W-1:0];
                CFG_COAST_FLOOR:     coast_floor_reg     <= cfg_data;
                default:             ;
            endcase
        end
    end

    // limit weights to one
    always_comb
    begin
        cfg.move_gate   = move_gate_reg;
        cfg.smooth_w    = (velocity_smooth_reg > WGT_ONE) ? WGT_ONE : velocity_smooth_reg;
        cfg.fling_max   = fling_max_reg;
        cfg.decay_w     = (inertia_decay_reg > WGT_ONE) ? WGT_ONE : inertia_decay_reg;
        cfg.coast_floor = coast_floor_reg;
    end

endmodule
`default_nettype wire

FILE: rtl/core/tks_update.sv
`timescale 1ns / 1ps
`default_nettype none
module tks_update
    import tks_pkg::*;
(
    input  wire cfg_t    cfg,
    input  wire frame_t  frame,
    input  wire state_t  cur,
    output state_t       nxt,
    output result_t      res
);

    logic                      start;
    logic                      t0;
    logic                      owa0;
    logic [POS_W-1:0]          press0;
    logic [POS_W-1:0]          sap0;
    logic [POS_W-1:0]          last0;
    logic [SPEED_W-1:0]        speed0;
    logic                      drag0;

    logic                      active;
    logic                      rel;
    logic signed [20:0]        dy;
    logic [20:0]               dy_abs;
    logic                      drag1;
    logic                      drag_wr;
    logic signed [22:0]        s_drag;
    logic [POS_W-1:0]          drag_pos;

    logic signed [20:0]        motion;
    logic [WGT_W-1:0]          w_old;
    logic [WGT_W-1:0]          w_new;
    logic signed [34:0]        ema_a;
    logic signed [34:0]        ema_b;
    logic signed [34:0]        ema_sum;
    logic [34:0]               ema_mag;
    logic [26:0]               ema_q;
    logic signed [27:0]        ema_r;
    logic [SPEED_W-1:0]        ema_sat;

    logic signed [24:0]        sp25;
    logic signed [24:0]        cap25;
    logic [SPEED_W-1:0]        speed_r;

    logic [SPEED_W-1:0]        sp_abs;
    logic                      inert;
    logic signed [25:0]        s_in;
    logic                      at_edge;
    logic [POS_W-1:0]          inert_pos;
    logic signed [33:0]        dec_prod;
    logic [33:0]               dec_mag;
    logic [25:0]               dec_q;
    logic [SPEED_W-1:0]        dec_speed;
    logic [SPEED_W-1:0]        speed_final;

    // touch start
    assign start  = frame.pointer_over & frame.pointer_down & ~cur.touching;
    assign t0     = cur.touching | start;
    assign owa0   = start ? frame.other_widget_active : cur.other_was_active;
    assign press0 = start ? frame.pointer_y  : cur.press_y;
    assign sap0   = start ? frame.scroll_now : cur.scroll_at_press;
    assign last0  = start ? frame.pointer_y  : cur.last_y;
    assign speed0 = start ? '0 : cur.speed;
    assign drag0  = start ? 1'b0 : cur.drag_on;

    assign active = t0 & frame.pointer_down;
    assign rel    = t0 & ~frame.pointer_down;

    // drag update
    assign dy      = $signed({frame.pointer_y[POS_W-1], frame.pointer_y})
                   - $signed({press0[POS_W-1], press0});
    assign dy_abs  = dy[20] ? (~dy + 21'd1) : dy;
    assign drag1   = drag0 | (active & ~owa0 & (dy_abs > {5'd0, cfg.move_gate}));
    assign drag_wr = active & drag1;
    assign s_drag  = $signed({3'b000, sap0}) - $signed({{2{dy[20]}}, dy});

    always_comb
    begin
        if (s_drag[22])
            drag_pos = '0;
        else if (s_drag[21:0] > {2'b00, frame.scroll_limit})
            drag_pos = frame.scroll_limit;
        else
            drag_pos = s_drag[POS_W-1:0];
    end

    assign motion  = $signed({last0[POS_W-1], last0})
                   - $signed({frame.pointer_y[POS_W-1], frame.pointer_y});
    assign w_old   = cfg.smooth_w;
    assign w_new   = WGT_ONE - cfg.smooth_w;
    assign ema_a   = $signed({26'd0, w_old}) * $signed({{11{speed0[SPEED_W-1]}}, speed0});
    assign ema_b   = $signed({26'd0, w_new}) * $signed({{14{motion[20]}}, motion});
    assign ema_sum = ema_a + ema_b;
    assign ema_mag = ema_sum[34] ? (~ema_sum + 35'd1) : ema_sum;
    assign ema_q   = 27'((ema_mag + 35'd128) >> 8);
    assign ema_r   = ema_sum[34] ? -$signed({1'b0, ema_q}) : $signed({1'b0, ema_q});

    always_comb
    begin
        if (ema_r > 28'sd8388607)
            ema_sat = 24'h7FFFFF;
        else if (ema_r < -28'sd8388608)
            ema_sat = 24'h800000;
        else
            ema_sat = ema_r[SPEED_W-1:0];
    end

    // release clamp
    assign sp25  = $signed({speed0[SPEED_W-1], speed0});
    assign cap25 = $signed({9'd0, cfg.fling_max});

    always_comb
    begin
        if (rel && (sp25 > cap25))
            speed_r = {8'd0, cfg.fling_max};
        else if (rel && (sp25 < -cap25))
            speed_r = 24'(-cap25);
        else
            speed_r = speed0;
    end

    // inertia
    assign sp_abs  = speed_r[SPEED_W-1] ? (~speed_r + 24'd1) : speed_r;
    assign inert   = ~active & (sp_abs > {8'd0, cfg.coast_floor});
    assign s_in    = $signed({6'd0, frame.scroll_now})
                   + $signed({{2{speed_r[SPEED_W-1]}}, speed_r});

    always_comb
    begin
        at_edge = 1'b1;
        if (s_in[25])
            inert_pos = '0;
        else if (s_in[24:0] > {5'd0, frame.scroll_limit})
            inert_pos = frame.scroll_limit;
        else
        begin
            inert_pos = s_in[POS_W-1:0];
            at_edge   = 1'b0;
        end
    end

    assign dec_prod  = $signed({{10{speed_r[SPEED_W-1]}}, speed_r}) * $signed({25'd0, cfg.decay_w});
    assign dec_mag   = dec_prod[33] ? (~dec_prod + 34'd1) : dec_prod;
    assign dec_q     = dec_mag[33:8];
    assign dec_speed = dec_prod[33] ? (~dec_q[SPEED_W-1:0] + 24'd1) : dec_q[SPEED_W-1:0];

    always_comb
    begin
        if (drag_wr)
            speed_final = ema_sat;
        else if (inert)
            speed_final = at_edge ? '0 : dec_speed;
        else
            speed_final = speed_r;
    end

    always_comb
    begin
        nxt.touching         = active;
        nxt.drag_on          = active & drag1;
        nxt.other_was_active = owa0;
        nxt.press_y          = press0;
        nxt.scroll_at_press  = sap0;
        nxt.last_y           = drag_wr ? frame.pointer_y : last0;
        nxt.speed            = speed_final;

        res.scroll_write  = drag_wr | inert;
        res.scroll_next   = drag_wr ? drag_pos : (inert ? inert_pos : '0);
        res.dragging      = active & drag1;
        res.swallow_press = drag_wr;
    end

endmodule
`default_nettype wire

FILE: rtl/core/touch_kinetic_scroll.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: input register, then result register; out_valid comes from the result register.
// Throughput: one frame per cycle unless out_ready stalls; one pass between the registers.
// Stall: a result held by out_ready low lets the input register take one more frame,
// then in_ready drops until the result transaction.
// Reset (rst_n low, asynchronous): state cleared, both registers empty, configuration default.
module touch_kinetic_scroll
    import tks_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             pointer_down,
    input  wire logic             pointer_over,
    input  wire logic [POS_W-1:0] pointer_y,
    input  wire logic [POS_W-1:0] scroll_now,
    input  wire logic [POS_W-1:0] scroll_limit,
    input  wire logic             other_widget_active,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  scroll_write,
    output logic [POS_W-1:0]      scroll_next,
    output logic                  dragging,
    output logic                  swallow_press,
    input  wire logic             cfg_we,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    cfg_t    cfg;
    frame_t  frame_reg;
    logic    frame_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_reg;
    result_t result_next;
    logic    result_valid_reg;
    logic    advance;

    tks_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tks_update u_update (
        .cfg   (cfg),
        .frame (frame_reg),
        .cur   (state_reg),
        .nxt   (state_next),
        .res   (result_next)
    );

    assign advance  = frame_valid_reg & (~result_valid_reg | out_ready);
    assign in_ready = ~frame_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '0;
        end
        else
        begin
            if (in_ready)
                frame_valid_reg <= in_valid;
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                state_reg        <= state_next;
            end
            else if (out_ready)
                result_valid_reg <= 1'b0;
        end
    end

    // hold payload until the next transaction
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            frame_reg.pointer_down        <= pointer_down;
            frame_reg.pointer_over        <= pointer_over;
            frame_reg.pointer_y           <= pointer_y;
            frame_reg.scroll_now          <= scroll_now;
            frame_reg.scroll_limit        <= scroll_limit;
            frame_reg.other_widget_active <= other_widget_active;
        end
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid     = result_valid_reg;
    assign scroll_write  = result_reg.scroll_write;
    assign scroll_next   = result_reg.scroll_next;
    assign dragging      = result_reg.dragging;
    assign swallow_press = result_reg.swallow_press;

endmodule
`default_nettype wire

FILE: dv/scroll_frame_checker.sv
`timescale 1ns / 1ps
module scroll_frame_checker
    import tks_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic             pointer_down,
    input  logic             pointer_over,
    input  logic [POS_W-1:0] pointer_y,
    input  logic [POS_W-1:0] scroll_now,
    input  logic [POS_W-1:0] scroll_limit,
    input  logic             other_widget_active,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic             scroll_write,
    input  logic [POS_W-1:0] scroll_next,
    input  logic             dragging,
    input  logic             swallow_press,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int unsigned      mismatches,
    output int unsigned      outstanding,
    output int unsigned      drag_updates,
    output int unsigned      coast_updates
);

    logic [CFG_W-1:0] thresh_r;
    logic [WGT_W-1:0] smooth_r;
    logic [CFG_W-1:0] cap_r;
    logic [WGT_W-1:0] decay_r;
    logic [CFG_W-1:0] stop_r;

    logic                      touching_q;
    logic                      drag_q;
    logic                      other_q;
    logic signed [POS_W-1:0]   press_y_q;
    logic [POS_W-1:0]          anchor_q;
    logic signed [POS_W-1:0]   last_y_q;
    logic signed [SPEED_W-1:0] speed_q;

    result_t expected_frames[$];
    result_t want;

    initial
    begin
        mismatches    = 0;
        outstanding   = 0;
        drag_updates  = 0;
        coast_updates = 0;
    end

    function automatic longint magnitude(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint div_by_256(longint x, bit round_near);
        longint q;
        q = (magnitude(x) + (round_near ? 128 : 0)) >> 8;
        return (x < 0) ? -q : q;
    endfunction

    function automatic logic signed [SPEED_W-1:0] saturate_speed(longint x);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (SPEED_W - 1)) - 1;
        lo = -(longint'(1) <<< (SPEED_W - 1));
        if (x > hi)
            return SPEED_W'(hi);
        if (x < lo)
            return SPEED_W'(lo);
        return SPEED_W'(x);
    endfunction

    function automatic result_t predict_frame(frame_t f);
        result_t r;
        longint  py, dy, pos, w, d, motion, cap;
        r  = '0;
        py = longint'($signed(f.pointer_y));

        if (f.pointer_over && f.pointer_down && !touching_q)
        begin
            touching_q = 1'b1;
            drag_q     = 1'b0;
            press_y_q  = f.pointer_y;
            anchor_q   = f.scroll_now;
            last_y_q   = f.pointer_y;
            speed_q    = '0;
            other_q    = f.other_widget_active;
        end

        if (touching_q && f.pointer_down)
        begin
            dy = py - longint'(press_y_q);
            if (!drag_q && !other_q && magnitude(dy) > longint'(thresh_r))
                drag_q = 1'b1;
            if (drag_q)
            begin
                pos    = longint'(anchor_q) - dy;
                w      = (smooth_r > WGT_ONE) ? longint'(WGT_ONE) : longint'(smooth_r);
                motion = longint'(last_y_q) - py;
                if (pos < 0)
                    pos = 0;
                if (pos > longint'(f.scroll_limit))
                    pos = longint'(f.scroll_limit);
                r.scroll_write  = 1'b1;
                r.scroll_next   = pos[POS_W-1:0];
                r.swallow_press = 1'b1;
                speed_q  = saturate_speed(div_by_256(w * longint'(speed_q)
                               + (longint'(WGT_ONE) - w) * motion, 1'b1));
                last_y_q = f.pointer_y;
            end
        end

        if (touching_q && !f.pointer_down)
        begin
            cap = longint'(cap_r);
            if (longint'(speed_q) > cap)
                speed_q = SPEED_W'(cap);
            if (longint'(speed_q) < -cap)
                speed_q = SPEED_W'(-cap);
            touching_q = 1'b0;
            drag_q     = 1'b0;
        end

        if (!touching_q && magnitude(longint'(speed_q)) > longint'(stop_r))
        begin
            pos = longint'(f.scroll_now) + longint'(speed_q);
            d   = (decay_r > WGT_ONE) ? longint'(WGT_ONE) : longint'(decay_r);
            if (pos < 0)
            begin
                pos     = 0;
                speed_q = '0;
            end
            else if (pos > longint'(f.scroll_limit))
            begin
                pos     = longint'(f.scroll_limit);
                speed_q = '0;
            end
            r.scroll_write = 1'b1;
            r.scroll_next  = pos[POS_W-1:0];
            speed_q = saturate_speed(div_by_256(longint'(speed_q) * d, 1'b0));
        end

        r.dragging = drag_q;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_r   = RST_MOVE_GATE;
            smooth_r   = RST_VELOCITY_SMOOTH;
            cap_r      = RST_FLING_MAX;
            decay_r    = RST_INERTIA_DECAY;
            stop_r     = RST_COAST_FLOOR;
            touching_q = 1'b0;
            drag_q     = 1'b0;
            other_q    = 1'b0;
            press_y_q  = '0;
            anchor_q   = '0;
            last_y_q   = '0;
            speed_q    = '0;
            expected_frames.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    $error("unexpected result transaction: scroll_write=%0d scroll_next=%0d",
                           scroll_write, scroll_next);
                    mismatches++;
                end
                else
                begin
                    want = expected_frames.pop_front();
                    check_field("scroll_write", want.scroll_write, scroll_write);
                    check_field("scroll_next", want.scroll_next, scroll_next);
                    check_field("dragging", want.dragging, dragging);
                    check_field("swallow_press", want.swallow_press, swallow_press);
                    if (want.swallow_press)
                        drag_updates++;
                    else if (want.scroll_write)
                        coast_updates++;
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MOVE_GATE:       thresh_r = cfg_data;
                    CFG_VELOCITY_SMOOTH: smooth_r = cfg_data[WGT_W-1:0];
                    CFG_FLING_MAX:       cap_r    = cfg_data;
                    CFG_INERTIA_DECAY:   decay_r  = cfg_data[WGT_W-1:0];
                    CFG_COAST_FLOOR:     stop_r   = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && in_ready)
                expected_frames.push_back(predict_frame(frame_t'{pointer_down, pointer_over,
                    pointer_y, scroll_now, scroll_limit, other_widget_active}));

            outstanding <= expected_frames.size();
        end
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import tks_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned SINK_HOLD   = 80;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic             pointer_down;
    logic             pointer_over;
    logic [POS_W-1:0] pointer_y;
    logic [POS_W-1:0] scroll_now;
    logic [POS_W-1:0] scroll_limit;
    logic             other_widget_active;
    logic             out_valid;
    logic             out_ready;
    logic             scroll_write;
    logic [POS_W-1:0] scroll_next;
    logic             dragging;
    logic             swallow_press;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned drag_updates;
    int unsigned coast_updates;

    int unsigned cycle_count    = 0;
    int unsigned frames_sent    = 0;
    int unsigned settings_used  = 1;
    int unsigned idle_pct       = 20;
    bit          sink_hold_req  = 1'b0;

    touch_kinetic_scroll uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .pointer_down        (pointer_down),
        .pointer_over        (pointer_over),
        .pointer_y           (pointer_y),
        .scroll_now          (scroll_now),
        .scroll_limit        (scroll_limit),
        .other_widget_active (other_widget_active),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .scroll_write        (scroll_write),
        .scroll_next         (scroll_next),
        .dragging            (dragging),
        .swallow_press       (swallow_press),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    scroll_frame_checker frame_chk (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .pointer_down        (pointer_down),
        .pointer_over        (pointer_over),
        .pointer_y           (pointer_y),
        .scroll_now          (scroll_now),
        .scroll_limit        (scroll_limit),
        .other_widget_active (other_widget_active),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .scroll_write        (scroll_write),
        .scroll_next         (scroll_next),
        .dragging            (dragging),
        .swallow_press       (swallow_press),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .mismatches          (mismatches),
        .outstanding         (outstanding),
        .drag_updates        (drag_updates),
        .coast_updates       (coast_updates)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycle_count, outstanding);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    initial
    begin
        int gap_left;
        int hold_left;
        bit hold_done;
        gap_left  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_req && !hold_done)
            begin
                hold_left = SINK_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                    gap_left = pick_gap();
            end
        end
    end

    task automatic send_frame(input bit down, input bit over, input int y, input int now,
                              input int lim, input bit other);
        int gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = pick_gap();
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid            <= 1'b1;
        pointer_down        <= down;
        pointer_over        <= over;
        pointer_y           <= POS_W'(y);
        scroll_now          <= POS_W'(now);
        scroll_limit        <= POS_W'(lim);
        other_widget_active <= other;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        frames_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_regs(input int thr, input int smooth, input int cap,
                              input int decay, input int stop);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MOVE_GATE;
        cfg_data  <= CFG_W'(thr);
        @(posedge clk);
        cfg_index <= CFG_VELOCITY_SMOOTH;
        cfg_data  <= CFG_W'(smooth);
        @(posedge clk);
        cfg_index <= CFG_FLING_MAX;
        cfg_data  <= CFG_W'(cap);
        @(posedge clk);
        cfg_index <= CFG_INERTIA_DECAY;
        cfg_data  <= CFG_W'(decay);
        @(posedge clk);
        cfg_index <= CFG_COAST_FLOOR;
        cfg_data  <= CFG_W'(stop);
        @(posedge clk);
        // unmapped index: must be dropped
        cfg_index <= IDX_W'(int'(CFG_COAST_FLOOR) + $urandom_range(1, 3));
        cfg_data  <= CFG_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic int pick_limit();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 20)
            return $urandom_range(0, 1048575);
        if (r < 30)
            return 1048575;
        return $urandom_range(0, 64000);
    endfunction

    function automatic int pick_position(int lim);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return $urandom_range(0, 1048575);
        if (r < 25)
            return 0;
        if (r < 40)
            return lim;
        return $urandom_range(0, lim);
    endfunction

    function automatic int pick_y();
        if ($urandom_range(0, 99) < 15)
            return int'($urandom_range(0, 1048575)) - 524288;
        return int'($urandom_range(0, 20000)) - 10000;
    endfunction

    task automatic send_noise();
        send_frame($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1048575),
                   $urandom_range(0, 1048575), $urandom_range(0, 1048575),
                   $urandom_range(0, 1));
    endtask

    task automatic run_gesture();
        int lim;
        int now;
        int y;
        int step;
        int drag_len;
        int coast_len;
        bit other;
        lim   = pick_limit();
        now   = pick_position(lim);
        y     = pick_y();
        other = ($urandom_range(0, 99) < 15);
        send_frame(1'b1, 1'b1, y, now, lim, other);
        drag_len = $urandom_range(0, 12);
        repeat (drag_len)
        begin
            if ($urandom_range(0, 99) < 10)
                step = int'($urandom_range(0, 200000)) - 100000;
            else
                step = int'($urandom_range(0, 800)) - 400;
            y = y + step;
            send_frame(1'b1, $urandom_range(0, 99) < 90, y, now, lim,
                       $urandom_range(0, 99) < 15);
        end
        send_frame(1'b0, $urandom_range(0, 1), y, now, lim, $urandom_range(0, 1));
        coast_len = $urandom_range(0, 15);
        repeat (coast_len)
        begin
            if ($urandom_range(0, 99) < 30)
                now = pick_position(lim);
            send_frame(1'b0, $urandom_range(0, 1), pick_y(), now, lim, $urandom_range(0, 1));
        end
    endtask

    task automatic run_until(input int unsigned target);
        int unsigned r;
        while (frames_sent < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                run_gesture();
            else if (r < 95)
                send_noise();
            else
                drain();
        end
    endtask

    task automatic write_random_regs();
        write_regs($urandom_range(0, 99) < 80 ? $urandom_range(0, 200) : $urandom_range(0, 65535),
                   $urandom_range(0, 511),
                   $urandom_range(0, 99) < 80 ? $urandom_range(0, 2000) : $urandom_range(0, 65535),
                   $urandom_range(0, 99) < 70 ? $urandom_range(150, 256) : $urandom_range(0, 511),
                   $urandom_range(0, 99) < 80 ? $urandom_range(0, 50) : $urandom_range(0, 65535));
    endtask

    initial
    begin
        int unsigned burst_end;
        rst_n               <= 1'b0;
        in_valid            <= 1'b0;
        pointer_down        <= 1'b0;
        pointer_over        <= 1'b0;
        pointer_y           <= '0;
        scroll_now          <= '0;
        scroll_limit        <= '0;
        other_widget_active <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_MOVE_GATE;
        cfg_data            <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_frame(0, 0, 0, 0, 0, 0);
        send_frame(1, 0, 100, 500, 2000, 0);
        send_frame(1, 1, 0, 1000, 2000, 1);
        send_frame(1, 1, 5000, 1000, 2000, 0);
        send_frame(0, 1, 5000, 1000, 2000, 0);
        send_frame(1, 1, 0, 1000, 2000, 0);
        send_frame(1, 1, 80, 1000, 2000, 0);
        send_frame(1, 1, -81, 1000, 2000, 0);
        send_frame(1, 1, -524288, 1000, 2000, 0);
        send_frame(1, 1, 524287, 1000, 2000, 0);
        send_frame(1, 0, -3000, 1000, 2000, 0);
        send_frame(0, 1, -3000, 1500, 2000, 0);
        send_frame(1, 1, 0, 40000, 80000, 0);
        send_frame(1, 1, -200, 40000, 80000, 0);
        send_frame(1, 1, -400, 40200, 80000, 0);
        send_frame(1, 1, -600, 40400, 80000, 0);
        send_frame(0, 0, -600, 40600, 80000, 0);
        send_frame(0, 0, 0, 40760, 80000, 0);
        send_frame(0, 1, 0, 40900, 80000, 1);
        send_frame(0, 0, 0, 1048575, 1000, 0);
        send_frame(1, 1, -524288, 1048575, 1048575, 0);
        send_frame(1, 1, 524287, 1048575, 1048575, 0);
        send_frame(1, 1, 524287, 1048575, 1048575, 1);
        send_frame(0, 0, 524287, 0, 1048575, 0);
        send_frame(0, 0, 0, 0, 1048575, 0);

        run_until(80);

        // hold the output side off while frames keep coming
        idle_pct      = 0;
        sink_hold_req = 1'b1;
        burst_end     = frames_sent + 30;
        while (frames_sent < burst_end)
            run_gesture();
        drain();
        idle_pct = 20;
        run_until(130);

        write_regs(0, 0, 65535, 256, 0);
        idle_pct = 0;
        run_until(180);

        write_regs(65535, 511, 0, 0, 65535);
        idle_pct = 35;
        run_until(220);

        write_regs(1, 256, 1, 511, 0);
        idle_pct = 15;
        run_until(260);

        repeat (3)
        begin
            write_random_regs();
            idle_pct = $urandom_range(0, 40);
            run_until(frames_sent + 47);
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Run covered %0d frames under %0d register settings, with back-pressure",
                 frames_sent, settings_used);
        $display("and drained pauses; checked %0d drag and %0d inertia updates, %0d mismatches",
                 drag_updates, coast_updates, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
